[rtl/core/quad_x_motor_mixer_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quad-X motor mixer
// Property wrappers that are compiled away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUAD_X_MOTOR_MIXER_UNIT_ASSERT_SVH
`define QUAD_X_MOTOR_MIXER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clock, idle while reset is high.
`define QXMM_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on clock, idle while reset is high.
`define QXMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define QXMM_ASSERT_IMPLY(label, ante, cons, msg)
`define QXMM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/core/qxmm_pkg.sv]
// ----------------------------------------------------------------------------
// Quad-X motor mixer package
// Widths, register codes and the job and mapping records shared by the block.
// ----------------------------------------------------------------------------
package qxmm_pkg;

   localparam int NUM_MOTORS = 4;
   localparam int DEMAND_W   = 16;
   localparam int MIX_W      = 18;   // signed sum of four demands
   localparam int LEVEL_W    = 18;   // demand after the shift, never negative
   localparam int QUO_W      = 15;   // normalized demand, 0 to 16384
   localparam int DIV_STEPS  = QUO_W;
   localparam int Q14_W      = 14;

   localparam logic [LEVEL_W-1:0] ONE_Q14 = LEVEL_W'(16384);

   localparam int PULSE_W   = 12;
   localparam int PULSE_LSB = 30;    // pulse sums are in Q30 microseconds
   localparam logic [PULSE_W-1:0] PULSE_TOP = '1;

   localparam int FLOOR_W = 12;
   localparam int FRAC_W  = 16;
   localparam int SPAN_W  = FLOOR_W + 1;
   localparam int MAP_W   = 30;      // Q16 microsecond pulse limits
   localparam int PROD_W  = 46;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [FLOOR_W-1:0] FLOOR_RESET   = 12'd1000;
   localparam logic [FLOOR_W-1:0] CEILING_RESET = 12'd2000;
   localparam logic [FRAC_W-1:0]  ARMED_RESET   = 16'd6554;
   localparam logic [FRAC_W-1:0]  TOP_RESET     = 16'd62259;

   typedef enum logic [1:0] {
      CSR_PULSE_FLOOR   = 2'd0,
      CSR_PULSE_CEILING = 2'd1,
      CSR_ARMED_SPIN    = 2'd2,
      CSR_TOP_SPIN      = 2'd3
   } csr_index_type;

   typedef logic [NUM_MOTORS-1:0][LEVEL_W-1:0] level_vec_type;

   typedef struct packed {
      level_vec_type        level;
      logic [LEVEL_W-1:0]   divisor;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_beat_type;

   typedef struct packed {
      logic signed [MAP_W-1:0] low;
      logic signed [MAP_W-1:0] diff;
   } map_type;

endpackage

[rtl/core/quad_x_motor_mixer_unit.sv]
// ----------------------------------------------------------------------------
// Quad-X motor mixer
// Turns roll, pitch, yaw and throttle demands into four motor pulse widths.
// ----------------------------------------------------------------------------
// The block takes one demand beat per clock while the input side is not
// stalled and returns one pulse beat for each, in order. Most of the
// pipeline is the fifteen-stage restoring divider that normalizes the
// demands, one quotient bit per stage, with two front-end stages, the job
// queue, the multiply and the output register making up the rest. Stalls on
// the output side back up into the job queue of QUEUE_DEPTH entries before
// the input side stops. Register writes reach the pulse mapping through the
// product, limit and map registers of the register file. Demands are signed
// Q2.14; pulses are whole microseconds, clamped to 0 through 4095.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_unit
   import qxmm_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   // Demand channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] roll_demand, [31:16] pitch_demand, [47:32] yaw_demand,
   // [63:48] throttle_demand
   input  logic [NUM_MOTORS*DEMAND_W-1:0]  req_tdata,
   // Pulse channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [11:0] rear_right_pulse, [23:12] front_right_pulse,
   // [35:24] rear_left_pulse, [47:36] front_left_pulse
   output logic [NUM_MOTORS*PULSE_W-1:0]   rsp_tdata,
   // Register port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]           csr_paddr,
   input  logic [CSR_DATA_W-1:0]           csr_pwdata,
   output logic [CSR_DATA_W-1:0]           csr_prdata,
   output logic                            csr_pready
);

   job_beat_type push;
   job_beat_type head;
   logic         queue_full;
   logic         pop;
   map_type      map;

   qxmm_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .map_o       (map)
   );

   qxmm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_o     (push),
      .queue_full (queue_full)
   );

   qxmm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push_i (push),
      .full_o (queue_full),
      .head_o (head),
      .pop_i  (pop)
   );

   qxmm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_i     (head),
      .pop_o      (pop),
      .map_i      (map),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/core/qxmm_cfg.sv]
// ----------------------------------------------------------------------------
// Quad-X mixer register file
// APB-style register port and the derived pulse limits used by the back end.
// ----------------------------------------------------------------------------
module qxmm_cfg
   import qxmm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output map_type               map_o
);

   logic [FLOOR_W-1:0] floor_ff;
   logic [FLOOR_W-1:0] ceiling_ff;
   logic [FRAC_W-1:0]  armed_ff;
   logic [FRAC_W-1:0]  top_ff;

   logic               wr_en;
   csr_index_type      index;

   logic signed [SPAN_W-1:0] span;
   logic signed [MAP_W-1:0]  prod_armed_in;
   logic signed [MAP_W-1:0]  prod_top_in;
   logic signed [MAP_W-1:0]  prod_armed_ff;
   logic signed [MAP_W-1:0]  prod_top_ff;
   logic [FLOOR_W-1:0]       floor_d_ff;
   logic signed [MAP_W-1:0]  base;
   logic signed [MAP_W-1:0]  low_ff;
   logic signed [MAP_W-1:0]  high_ff;
   map_type                  map_ff;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= FLOOR_RESET;
         ceiling_ff <= CEILING_RESET;
         armed_ff   <= ARMED_RESET;
         top_ff     <= TOP_RESET;
      end else if (wr_en) begin
         unique case (index)
            CSR_PULSE_FLOOR:   floor_ff   <= csr_pwdata[FLOOR_W-1:0];
            CSR_PULSE_CEILING: ceiling_ff <= csr_pwdata[FLOOR_W-1:0];
            CSR_ARMED_SPIN:    armed_ff   <= csr_pwdata[FRAC_W-1:0];
            CSR_TOP_SPIN:      top_ff     <= csr_pwdata[FRAC_W-1:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_PULSE_FLOOR:   csr_prdata = CSR_DATA_W'(floor_ff);
         CSR_PULSE_CEILING: csr_prdata = CSR_DATA_W'(ceiling_ff);
         CSR_ARMED_SPIN:    csr_prdata = CSR_DATA_W'(armed_ff);
         CSR_TOP_SPIN:      csr_prdata = CSR_DATA_W'(top_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // The limits follow the registers through the product, limit and map
   // registers, a shorter path than items take to reach the pulse mapping.
   assign span          = $signed({1'b0, ceiling_ff}) - $signed({1'b0, floor_ff});
   assign prod_armed_in = MAP_W'(span) * MAP_W'($signed({1'b0, armed_ff}));
   assign prod_top_in   = MAP_W'(span) * MAP_W'($signed({1'b0, top_ff}));
   assign base          = $signed(MAP_W'({floor_d_ff, FRAC_W'(0)}));

   always_ff @(posedge clock) begin
      prod_armed_ff <= prod_armed_in;
      prod_top_ff   <= prod_top_in;
      floor_d_ff    <= floor_ff;
      low_ff        <= base + prod_armed_ff;
      high_ff       <= base + prod_top_ff;
      map_ff.low    <= low_ff;
      map_ff.diff   <= high_ff - low_ff;
   end

   assign map_o = map_ff;

endmodule

[rtl/core/qxmm_front.sv]
// ----------------------------------------------------------------------------
// Quad-X mixer front end
// Mixes the four demands, lifts them out of negative range and picks the
// divisor that normalizes them, then hands the job to the queue.
// ----------------------------------------------------------------------------
`include "quad_x_motor_mixer_unit_assert.svh"

module qxmm_front
   import qxmm_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [NUM_MOTORS*DEMAND_W-1:0]   req_tdata,
   output job_beat_type                     push_o,
   input  logic                             queue_full
);

   logic                     adv;
   logic signed [MIX_W-1:0]  roll, pitch, yaw, throttle;
   logic signed [MIX_W-1:0]  mix_in [NUM_MOTORS];
   logic signed [MIX_W-1:0]  mix_ff [NUM_MOTORS];
   logic                     mix_valid_ff;

   logic signed [MIX_W-1:0]  lo01, lo23, lo;
   logic signed [MIX_W:0]    lifted [NUM_MOTORS];
   level_vec_type            level_in;
   level_vec_type            level_ff;
   logic                     level_valid_ff;

   logic [LEVEL_W-1:0]       hi01, hi23, hi;
   logic [LEVEL_W-1:0]       divisor;

   assign adv        = !level_valid_ff || !queue_full;
   assign req_tready = adv;

   assign roll     = MIX_W'($signed(req_tdata[DEMAND_W-1:0]));
   assign pitch    = MIX_W'($signed(req_tdata[2*DEMAND_W-1:DEMAND_W]));
   assign yaw      = MIX_W'($signed(req_tdata[3*DEMAND_W-1:2*DEMAND_W]));
   assign throttle = MIX_W'($signed(req_tdata[4*DEMAND_W-1:3*DEMAND_W]));

   always_comb begin
      mix_in[0] = throttle - roll + pitch + yaw;
      mix_in[1] = throttle - roll - pitch - yaw;
      mix_in[2] = throttle + roll + pitch - yaw;
      mix_in[3] = throttle + roll - pitch + yaw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_valid_ff   <= 1'b0;
         level_valid_ff <= 1'b0;
      end else if (adv) begin
         mix_valid_ff   <= req_tvalid;
         level_valid_ff <= mix_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mix_ff   <= mix_in;
         level_ff <= level_in;
      end
   end

   // A negative minimum raises every demand so that the lowest one sits at zero.
   assign lo01 = (mix_ff[0] < mix_ff[1]) ? mix_ff[0] : mix_ff[1];
   assign lo23 = (mix_ff[2] < mix_ff[3]) ? mix_ff[2] : mix_ff[3];
   assign lo   = (lo01 < lo23) ? lo01 : lo23;

   always_comb begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
         lifted[k] = (MIX_W+1)'(mix_ff[k]) - (lo[MIX_W-1] ? (MIX_W+1)'(lo) : '0);
         level_in[k] = lifted[k][LEVEL_W-1:0];
      end
   end

   // A divisor of one leaves the demands unchanged in the back end.
   assign hi01    = (level_ff[0] > level_ff[1]) ? level_ff[0] : level_ff[1];
   assign hi23    = (level_ff[2] > level_ff[3]) ? level_ff[2] : level_ff[3];
   assign hi      = (hi01 > hi23) ? hi01 : hi23;
   assign divisor = (hi > ONE_Q14) ? hi : ONE_Q14;

   assign push_o.valid       = level_valid_ff && !queue_full;
   assign push_o.job.level   = level_ff;
   assign push_o.job.divisor = divisor;

   `QXMM_ASSERT_IMPLY(a_level_within_divisor, level_valid_ff,
      (level_ff[0] <= divisor) && (level_ff[1] <= divisor) &&
      (level_ff[2] <= divisor) && (level_ff[3] <= divisor), "demand exceeds its divisor")

endmodule

[rtl/core/qxmm_queue.sv]
// ----------------------------------------------------------------------------
// Quad-X mixer job queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`include "quad_x_motor_mixer_unit_assert.svh"

module qxmm_queue
   import qxmm_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  job_beat_type  push_i,
   output logic          full_o,
   output job_beat_type  head_o,
   input  logic          pop_i
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   job_type              mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [COUNT_W-1:0]   count_ff;

   assign full_o       = (count_ff == COUNT_W'(DEPTH));
   assign head_o.valid = (count_ff != '0);
   assign head_o.job   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_i.valid) begin
         mem_ff[wr_ptr_ff] <= push_i.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_i.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop_i) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push_i.valid && !pop_i) begin
            count_ff <= count_ff + COUNT_W'(1);
         end else if (pop_i && !push_i.valid) begin
            count_ff <= count_ff - COUNT_W'(1);
         end
      end
   end

   `QXMM_ASSERT_IMPLY(a_no_push_when_full, push_i.valid, !full_o, "queue written while full")
   `QXMM_ASSERT_IMPLY(a_no_pop_when_empty, pop_i, head_o.valid, "queue read while empty")

endmodule

[rtl/core/qxmm_back.sv]
// ----------------------------------------------------------------------------
// Quad-X mixer back end
// Normalizes the demands with a pipelined restoring divider, maps them onto
// the pulse range and holds the result beat for the output channel.
// ----------------------------------------------------------------------------
`include "quad_x_motor_mixer_unit_assert.svh"

module qxmm_back
   import qxmm_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  job_beat_type                    head_i,
   output logic                            pop_o,
   input  map_type                         map_i,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [NUM_MOTORS*PULSE_W-1:0]   rsp_tdata
);

   logic                      adv;

   logic                      div_valid_in [DIV_STEPS];
   logic                      div_valid_ff [DIV_STEPS];
   logic [LEVEL_W-1:0]        dvs_in [DIV_STEPS];
   logic [LEVEL_W-1:0]        dvs_ff [DIV_STEPS];
   logic [LEVEL_W-1:0]        rem_in [DIV_STEPS][NUM_MOTORS];
   logic [LEVEL_W-1:0]        rem_ff [DIV_STEPS][NUM_MOTORS];
   logic [QUO_W-1:0]          quo_in [DIV_STEPS][NUM_MOTORS];
   logic [QUO_W-1:0]          quo_ff [DIV_STEPS][NUM_MOTORS];
   logic                      quo_in_range;

   logic signed [PROD_W-1:0]  prod_in [NUM_MOTORS];
   logic signed [PROD_W-1:0]  prod_ff [NUM_MOTORS];
   logic                      mul_valid_ff;

   logic [NUM_MOTORS-1:0][PULSE_W-1:0] pulse_in;
   logic [NUM_MOTORS-1:0][PULSE_W-1:0] pulse_ff;
   logic                               rsp_valid_ff;

   // The whole back end moves as one pipeline whenever the output beat can go.
   assign adv   = !rsp_valid_ff || rsp_tready;
   assign pop_o = head_i.valid && adv;

   // One quotient bit per stage. The first stage decides the integer bit, the
   // following fourteen shift in fraction bits. A divisor of one passes the
   // demand through unchanged.
   always_comb begin
      logic [LEVEL_W:0]   trial;
      logic [LEVEL_W:0]   less;
      logic [LEVEL_W-1:0] d_src;
      logic [QUO_W-1:0]   q_src;
      logic               ge;
      for (int s = 0; s < DIV_STEPS; s++) begin
         if (s == 0) begin
            div_valid_in[s] = head_i.valid;
            dvs_in[s]       = head_i.job.divisor;
         end else begin
            div_valid_in[s] = div_valid_ff[s-1];
            dvs_in[s]       = dvs_ff[s-1];
         end
         for (int k = 0; k < NUM_MOTORS; k++) begin
            if (s == 0) begin
               d_src = head_i.job.divisor;
               q_src = '0;
               trial = {1'b0, head_i.job.level[k]};
            end else begin
               d_src = dvs_ff[s-1];
               q_src = quo_ff[s-1][k];
               trial = {rem_ff[s-1][k], 1'b0};
            end
            less = trial - {1'b0, d_src};
            ge   = (trial >= {1'b0, d_src});
            rem_in[s][k] = ge ? less[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
            quo_in[s][k] = {q_src[QUO_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            div_valid_ff[s] <= 1'b0;
         end
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         div_valid_ff <= div_valid_in;
         mul_valid_ff <= div_valid_ff[DIV_STEPS-1];
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dvs_ff   <= dvs_in;
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         prod_ff  <= prod_in;
         pulse_ff <= pulse_in;
      end
   end

   always_comb begin
      logic signed [QUO_W:0] qs;
      for (int k = 0; k < NUM_MOTORS; k++) begin
         qs         = $signed({1'b0, quo_ff[DIV_STEPS-1][k]});
         prod_in[k] = PROD_W'(qs) * PROD_W'(map_i.diff);
      end
   end

   // Pulse in Q30 microseconds, truncated and clamped to the field.
   always_comb begin
      logic signed [PROD_W-1:0] base;
      logic signed [PROD_W-1:0] sum;
      base = $signed({{(PROD_W-MAP_W-Q14_W){map_i.low[MAP_W-1]}}, map_i.low, Q14_W'(0)});
      for (int k = 0; k < NUM_MOTORS; k++) begin
         sum = base + prod_ff[k];
         if (sum[PROD_W-1]) begin
            pulse_in[k] = '0;
         end else if (|sum[PROD_W-2:PULSE_LSB+PULSE_W]) begin
            pulse_in[k] = PULSE_TOP;
         end else begin
            pulse_in[k] = sum[PULSE_LSB+PULSE_W-1:PULSE_LSB];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pulse_ff;

   always_comb begin
      quo_in_range = 1'b1;
      for (int k = 0; k < NUM_MOTORS; k++) begin
         if (LEVEL_W'(quo_ff[DIV_STEPS-1][k]) > ONE_Q14) begin
            quo_in_range = 1'b0;
         end
      end
   end

   `QXMM_ASSERT_IMPLY(a_quotient_in_range, div_valid_ff[DIV_STEPS-1], quo_in_range,
      "normalized demand above one")
   `QXMM_ASSERT_IMPLY(a_result_from_multiply, $rose(rsp_valid_ff), $past(mul_valid_ff),
      "result beat without a product")
   `QXMM_ASSERT_NEXT(a_stall_holds_pipe, rsp_valid_ff && !rsp_tready && mul_valid_ff,
      mul_valid_ff, "product lost during a stall")

endmodule

[bench/qxmm_pulse_checker.sv]
// ----------------------------------------------------------------------------
// Pulse checker for the quad-X motor mixer
// Follows the register writes, works out the four pulse widths of every
// accepted demand beat and compares them, in order, with the pulse beats.
// ----------------------------------------------------------------------------
module qxmm_pulse_checker
   import qxmm_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [NUM_MOTORS*DEMAND_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [NUM_MOTORS*PULSE_W-1:0]  rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [CSR_DATA_W-1:0]          csr_pwdata,
   input  logic                           csr_pready,
   output int                             mismatch_count,
   output int                             pulses_owed
);

   localparam longint UNIT_LEVEL = longint'(ONE_Q14);

   typedef struct packed {
      logic signed [DEMAND_W-1:0] throttle;
      logic signed [DEMAND_W-1:0] yaw;
      logic signed [DEMAND_W-1:0] pitch;
      logic signed [DEMAND_W-1:0] roll;
   } demand_set_type;

   typedef struct packed {
      logic [PULSE_W-1:0] front_left;
      logic [PULSE_W-1:0] rear_left;
      logic [PULSE_W-1:0] front_right;
      logic [PULSE_W-1:0] rear_right;
   } pulse_set_type;

   logic [FLOOR_W-1:0] floor_us;
   logic [FLOOR_W-1:0] ceiling_us;
   logic [FRAC_W-1:0]  armed_frac;
   logic [FRAC_W-1:0]  top_frac;
   pulse_set_type      pulses_due[$];

   // The pulse is held in Q30 microseconds until it is truncated.
   function automatic logic [PULSE_W-1:0] level_to_pulse(input longint level,
                                                         input longint low_q16,
                                                         input longint high_q16);
      longint q30;
      q30 = low_q16 * UNIT_LEVEL + level * (high_q16 - low_q16);
      if (q30 < 0) return '0;
      q30 = q30 >>> PULSE_LSB;
      if (q30 > longint'(PULSE_TOP)) return PULSE_TOP;
      return PULSE_W'(q30);
   endfunction

   function automatic pulse_set_type mix_to_pulses(input demand_set_type demands);
      longint        roll, pitch, yaw, throttle;
      longint        level[NUM_MOTORS];
      longint        low_level, high_level, span, low_q16, high_q16;
      pulse_set_type pulses;
      roll     = demands.roll;
      pitch    = demands.pitch;
      yaw      = demands.yaw;
      throttle = demands.throttle;
      level[0] = -roll + pitch + yaw + throttle;
      level[1] = -roll - pitch - yaw + throttle;
      level[2] =  roll + pitch - yaw + throttle;
      level[3] =  roll - pitch + yaw + throttle;

      low_level = level[0];
      foreach (level[k]) if (level[k] < low_level) low_level = level[k];
      if (low_level < 0) begin
         foreach (level[k]) level[k] -= low_level;
      end

      // The largest demand is brought back to one, the rest in proportion.
      high_level = level[0];
      foreach (level[k]) if (level[k] > high_level) high_level = level[k];
      if (high_level > UNIT_LEVEL) begin
         foreach (level[k]) level[k] = (level[k] * UNIT_LEVEL) / high_level;
      end

      span     = longint'(ceiling_us) - longint'(floor_us);
      low_q16  = (longint'(floor_us) << FRAC_W) + span * longint'(armed_frac);
      high_q16 = (longint'(floor_us) << FRAC_W) + span * longint'(top_frac);

      pulses.rear_right  = level_to_pulse(level[0], low_q16, high_q16);
      pulses.front_right = level_to_pulse(level[1], low_q16, high_q16);
      pulses.rear_left   = level_to_pulse(level[2], low_q16, high_q16);
      pulses.front_left  = level_to_pulse(level[3], low_q16, high_q16);
      return pulses;
   endfunction

   task automatic compare_pulse(input string name, input logic [PULSE_W-1:0] want,
                                input logic [PULSE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      pulse_set_type seen;
      pulse_set_type want;
      if (reset) begin
         floor_us    = FLOOR_RESET;
         ceiling_us  = CEILING_RESET;
         armed_frac  = ARMED_RESET;
         top_frac    = TOP_RESET;
         pulses_due.delete();
         pulses_owed = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               CSR_PULSE_FLOOR:   floor_us   = csr_pwdata[FLOOR_W-1:0];
               CSR_PULSE_CEILING: ceiling_us = csr_pwdata[FLOOR_W-1:0];
               CSR_ARMED_SPIN:    armed_frac = csr_pwdata[FRAC_W-1:0];
               CSR_TOP_SPIN:      top_frac   = csr_pwdata[FRAC_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            pulses_due.push_back(mix_to_pulses(demand_set_type'(req_tdata)));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = pulse_set_type'(rsp_tdata);
            if (pulses_due.size() == 0) begin
               $error("pulse beat arrived with no demand beat waiting for it");
               mismatch_count++;
            end else begin
               want = pulses_due.pop_front();
               compare_pulse("rear_right_pulse", want.rear_right, seen.rear_right);
               compare_pulse("front_right_pulse", want.front_right, seen.front_right);
               compare_pulse("rear_left_pulse", want.rear_left, seen.rear_left);
               compare_pulse("front_left_pulse", want.front_left, seen.front_left);
            end
         end
         pulses_owed = pulses_due.size();
      end
   end

endmodule

[bench/tb_quad_x_motor_mixer_unit.sv]
// ----------------------------------------------------------------------------
// Testbench for the quad-X motor mixer
// Drives demand beats under a series of register settings, with random gaps
// on the demand side and random stalls on the pulse side, and leaves the
// checking to the pulse checker.
// ----------------------------------------------------------------------------
module tb_quad_x_motor_mixer_unit;
   import qxmm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASES         = 12;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   // [15:0] roll_demand, [31:16] pitch_demand, [47:32] yaw_demand,
   // [63:48] throttle_demand
   logic [NUM_MOTORS*DEMAND_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   // [11:0] rear_right_pulse, [23:12] front_right_pulse,
   // [35:24] rear_left_pulse, [47:36] front_left_pulse
   logic [NUM_MOTORS*PULSE_W-1:0]  rsp_tdata;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [CSR_ADDR_W-1:0]          csr_paddr;
   logic [CSR_DATA_W-1:0]          csr_pwdata;
   logic [CSR_DATA_W-1:0]          csr_prdata;
   logic                           csr_pready;

   bit steady;
   int mismatch_count;
   int pulses_owed;
   int idle_cycles;

   quad_x_motor_mixer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   qxmm_pulse_checker pulse_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pulses_owed    (pulses_owed)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_quad_x_motor_mixer_unit: errors");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll_of_dice;
      roll_of_dice = $urandom_range(0, 99);
      if (roll_of_dice < 80) return $urandom_range(1, 3);
      if (roll_of_dice < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DEMAND_W-1:0] pick_corner();
      case ($urandom_range(0, 6))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'h4000;
         4:       return 16'hC000;
         5:       return 16'h0001;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [NUM_MOTORS*DEMAND_W-1:0] pack_demands(
         input logic [DEMAND_W-1:0] roll, input logic [DEMAND_W-1:0] pitch,
         input logic [DEMAND_W-1:0] yaw, input logic [DEMAND_W-1:0] throttle);
      return {throttle, yaw, pitch, roll};
   endfunction

   // Hand-picked beats: field extremes, a demand exactly at zero and at one,
   // just above one, shifts, scaling and alternating bit patterns.
   function automatic logic [NUM_MOTORS*DEMAND_W-1:0] directed_demands(input int n);
      case (n)
         0:       return pack_demands(16'd0, 16'd0, 16'd0, 16'd0);
         1:       return pack_demands(16'd0, 16'd0, 16'd0, 16'd16384);
         2:       return pack_demands(16'd0, 16'd0, 16'd0, 16'd8192);
         3:       return pack_demands(16'd0, 16'd0, 16'd0, 16'd16385);
         4:       return pack_demands(16'd0, 16'd0, 16'd0, 16'h7FFF);
         5:       return pack_demands(16'd0, 16'd0, 16'd0, 16'h8000);
         6:       return pack_demands(16'h7FFF, 16'd0, 16'd0, 16'd0);
         7:       return pack_demands(16'h8000, 16'd0, 16'd0, 16'd0);
         8:       return pack_demands(16'd0, 16'h7FFF, 16'd0, 16'd8192);
         9:       return pack_demands(16'd0, 16'h8000, 16'd0, 16'd8192);
         10:      return pack_demands(16'd0, 16'd0, 16'h7FFF, 16'd16384);
         11:      return pack_demands(16'd0, 16'd0, 16'h8000, 16'd16384);
         12:      return pack_demands(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
         13:      return pack_demands(16'h8000, 16'h8000, 16'h8000, 16'h8000);
         14:      return pack_demands(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
         15:      return pack_demands(16'h5555, 16'h5555, 16'h5555, 16'h5555);
         16:      return pack_demands(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA);
         17:      return pack_demands(16'd1000, -16'sd1000, 16'd500, 16'd12000);
         18:      return pack_demands(16'd4096, 16'd4096, 16'd0, 16'd8192);
         default: return pack_demands(16'd16384, 16'd0, 16'd0, 16'd0);
      endcase
   endfunction

   function automatic logic [NUM_MOTORS*DEMAND_W-1:0] random_demands();
      logic [DEMAND_W-1:0] axis[NUM_MOTORS];
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            foreach (axis[k]) axis[k] = DEMAND_W'($urandom);
         end
         // Flight-like demands: throttle within [0,1], small corrections.
         3, 4, 5, 6: begin
            foreach (axis[k]) axis[k] = DEMAND_W'($urandom_range(0, 8000)) - 16'd4000;
            axis[3] = DEMAND_W'($urandom_range(0, 16384));
         end
         7: begin
            foreach (axis[k]) axis[k] = pick_corner();
         end
         default: begin
            foreach (axis[k]) axis[k] = DEMAND_W'($urandom_range(0, 24000)) - 16'd12000;
            axis[3] = DEMAND_W'($urandom_range(12000, 32767));
         end
      endcase
      return pack_demands(axis[0], axis[1], axis[2], axis[3]);
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_demands(input logic [NUM_MOTORS*DEMAND_W-1:0] beat);
      int gap;
      gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         req_tdata  = {$urandom, $urandom};
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = beat;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         send_demands(random_demands());
      end
      req_tvalid = 1'b0;
      steady     = 1'b0;
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Junk in the upper bits checks that the block masks each register.
   task automatic set_pulse_range(input logic [FLOOR_W-1:0] floor_us,
                                  input logic [FLOOR_W-1:0] ceiling_us,
                                  input logic [FRAC_W-1:0] armed_frac,
                                  input logic [FRAC_W-1:0] top_frac);
      write_register(CSR_PULSE_FLOOR, {20'($urandom), floor_us});
      write_register(CSR_PULSE_CEILING, {20'($urandom), ceiling_us});
      write_register(CSR_ARMED_SPIN, {16'($urandom), armed_frac});
      write_register(CSR_TOP_SPIN, {16'($urandom), top_frac});
   endtask

   task automatic wait_for_pulses();
      while (pulses_owed != 0) @(negedge clock);
   endtask

   initial begin
      int hold;
      rsp_tready = 1'b0;
      hold       = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (steady || $urandom_range(0, 3) != 0) begin
            rsp_tready = 1'b1;
            hold       = $urandom_range(0, 10);
         end else begin
            rsp_tready = 1'b0;
            hold       = pick_gap() - 1;
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      steady      = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      for (int n = 0; n < 20; n++) send_demands(directed_demands(n));
      req_tvalid = 1'b0;
      send_random(120);

      for (int phase = 1; phase < PHASES; phase++) begin
         wait_for_pulses();
         case (phase)
            1:       set_pulse_range(12'd0, 12'd4095, 16'd0, 16'hFFFF);
            // Ceiling below floor: the mapping runs downward.
            2:       set_pulse_range(12'd4095, 12'd0, 16'd0, 16'hFFFF);
            // Top fraction below the armed fraction.
            3:       set_pulse_range(12'd1000, 12'd2000, 16'd62259, 16'd6554);
            4:       set_pulse_range(12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF);
            5:       set_pulse_range(12'd0, 12'd0, 16'd0, 16'd0);
            default: set_pulse_range(FLOOR_W'($urandom), FLOOR_W'($urandom),
                                     FRAC_W'($urandom), FRAC_W'($urandom));
         endcase
         send_random(phase < 6 ? 60 : 220);
      end

      wait_for_pulses();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pulses_owed == 0) begin
         $display("tb_quad_x_motor_mixer_unit: clean");
      end else begin
         $display("tb_quad_x_motor_mixer_unit: errors");
      end
      $finish;
   end

endmodule
